@@ rtl/gva_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gva_pkg;

	localparam int SLOTS_DEF      = 32;
	localparam int MAX_ACTIVE_DEF = 16;

	localparam int BIRTH_W = 48;
	localparam int AGE_W   = 16;
	localparam int FADE_W  = 17;
	localparam int SLOT_OW = 5;   // slot index width on the result beat
	localparam int CNT_W   = 6;

	localparam logic [FADE_W-1:0] FADE_UNITY      = 17'd65536;
	localparam logic [FADE_W-1:0] FADE_STEP_RESET = 17'd683;

	typedef struct packed {
		logic [BIRTH_W-1:0] birth;
		logic [AGE_W-1:0]   age;
		logic [AGE_W-1:0]   length;
		logic [FADE_W-1:0]  fade;
	} slot_entry_t;

	typedef struct packed {
		slot_entry_t        entry;
		logic               stolen;
		logic [FADE_W-1:0]  fade_step;
		logic [BIRTH_W-1:0] best_birth;
	} alu_req_t;

	typedef struct packed {
		slot_entry_t entry;   // entry after one tick
		logic        done;    // slot retires on this tick
		logic        older;   // birth below the current best
	} alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/grain_voice_allocator_with_stealing.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Grain voice allocator with oldest-voice stealing.
// Input stream: s_axis_tuser = mode (0 tick, 1 spawn), s_axis_tdata = grain_length.
// Result stream: one beat per input beat on m_axis_*, fields listed at the port.
// cfg_valid/cfg_data write fade_step (Q1.16, 65536 = unity); cfg_ready is always high.
// Each item makes one pass over all SLOTS entries through a single slot RAM read
// port and one shared slot unit, stepping through the scan, commit and result
// states once accepted; the result state loads the result register once it is free.
// The slot RAM's one read per cycle sets the length of the scan. s_axis_tready
// is high only while no item is in progress.
// A finished result waits in the output register; the next item is accepted while
// it waits, but a second result is held back until the receiver takes the first.
// Reset clears all slot flags, the active count and the birth counter, and loads
// fade_step with 683. Slot payload RAM needs no clearing: its contents are used
// only for slots that a spawn has written.
module grain_voice_allocator_with_stealing #(
	parameter int SLOTS      = gva_pkg::SLOTS_DEF,
	parameter int MAX_ACTIVE = gva_pkg::MAX_ACTIVE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output wire logic        cfg_ready,
	input  wire logic [16:0] cfg_data,       // fade_step
	input  wire logic        s_axis_tvalid,
	output wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // grain_length
	input  wire logic [0:0]  s_axis_tuser,   // mode
	output wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// granted[0], granted_slot[5:1], stole[6], stolen_slot[11:7], dropped[12],
	// active_count[18:13], retired_count[24:19], zero[31:25]
	output wire logic [31:0] m_axis_tdata
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW     = gva_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [SLOTS-1:0]             active_q;
	logic [SLOTS-1:0]             stolen_q;
	logic [CW-1:0]                counted_q;
	logic [gva_pkg::BIRTH_W-1:0]  birth_ctr_q;
	logic [gva_pkg::FADE_W-1:0]   fade_step_q;
	logic                         spawn_q;
	logic [gva_pkg::AGE_W-1:0]    len_q;
	logic [SLOT_W-1:0]            rd_idx_q;
	logic                         issue_done_q;
	logic                         vld_s1;
	logic [SLOT_W-1:0]            idx_s1;
	logic                         steal_need_q;
	logic                         old_found_q;
	logic [SLOT_W-1:0]            old_idx_q;
	logic [gva_pkg::BIRTH_W-1:0]  best_q;
	logic                         free_found_q;
	logic [SLOT_W-1:0]            free_idx_q;
	logic [CW-1:0]                retired_q;
	logic                         out_vld_q;
	logic [31:0]                  out_data_q;

	gva_pkg::slot_entry_t rd_entry;
	gva_pkg::slot_entry_t wr_entry;
	logic                 wr_en;
	logic [SLOT_W-1:0]    wr_addr;
	gva_pkg::alu_req_t    alu_req;
	gva_pkg::alu_rsp_t    alu_rsp;

	logic in_beat;
	logic slot_act;
	logic slot_stl;
	logic out_free;
	logic granted;
	logic stole;
	logic [31:0] result;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_vld_q || m_axis_tready;

	assign slot_act = active_q[idx_s1];
	assign slot_stl = stolen_q[idx_s1];

	assign alu_req.entry      = rd_entry;
	assign alu_req.stolen     = slot_stl;
	assign alu_req.fade_step  = fade_step_q;
	assign alu_req.best_birth = best_q;

	gva_slot_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	always_comb begin
		wr_entry        = alu_rsp.entry;
		wr_addr         = idx_s1;
		wr_en           = (state_q == ST_SCAN) && vld_s1 && !spawn_q && slot_act;
		if (state_q == ST_COMMIT) begin
			wr_entry.birth  = birth_ctr_q;
			wr_entry.age    = '0;
			wr_entry.length = len_q;
			wr_entry.fade   = gva_pkg::FADE_UNITY;
			wr_addr         = free_idx_q;
			wr_en           = spawn_q && free_found_q;
		end
	end

	gva_slot_ram #(
		.DEPTH (SLOTS),
		.AW    (SLOT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_addr (rd_idx_q),
		.rd_data (rd_entry)
	);

	assign granted = spawn_q && free_found_q;
	assign stole   = spawn_q && old_found_q;
	assign result  = {7'd0,
		retired_q,
		counted_q,
		spawn_q && !free_found_q,
		stole ? gva_pkg::SLOT_OW'(old_idx_q) : gva_pkg::SLOT_OW'(0),
		stole,
		granted ? gva_pkg::SLOT_OW'(free_idx_q) : gva_pkg::SLOT_OW'(0),
		granted};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			active_q     <= '0;
			stolen_q     <= '0;
			counted_q    <= '0;
			birth_ctr_q  <= '0;
			fade_step_q  <= gva_pkg::FADE_STEP_RESET;
			spawn_q      <= 1'b0;
			len_q        <= '0;
			rd_idx_q     <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			steal_need_q <= 1'b0;
			old_found_q  <= 1'b0;
			old_idx_q    <= '0;
			best_q       <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			retired_q    <= '0;
			out_vld_q    <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (cfg_valid) begin
				fade_step_q <= cfg_data;
			end
			if ((state_q == ST_RESULT) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						spawn_q      <= s_axis_tuser[0];
						len_q        <= (s_axis_tdata == '0) ? gva_pkg::AGE_W'(1) : s_axis_tdata;
						rd_idx_q     <= '0;
						issue_done_q <= 1'b0;
						vld_s1       <= 1'b0;
						old_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						retired_q    <= '0;
						steal_need_q <= counted_q >= CW'(MAX_ACTIVE);
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue side: one RAM read per cycle
					vld_s1 <= !issue_done_q;
					idx_s1 <= rd_idx_q;
					if (!issue_done_q) begin
						if (rd_idx_q == SLOT_W'(SLOTS - 1)) begin
							issue_done_q <= 1'b1;
						end else begin
							rd_idx_q <= rd_idx_q + SLOT_W'(1);
						end
					end
					// process side: entry read last cycle
					if (vld_s1) begin
						if (spawn_q) begin
							if (steal_need_q && slot_act && !slot_stl &&
							    (!old_found_q || alu_rsp.older)) begin
								old_found_q <= 1'b1;
								old_idx_q   <= idx_s1;
								best_q      <= rd_entry.birth;
							end
							if (!slot_act && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= idx_s1;
							end
						end else if (slot_act && alu_rsp.done) begin
							active_q[idx_s1] <= 1'b0;
							if (!slot_stl && counted_q != '0) begin
								counted_q <= counted_q - CW'(1);
							end
							retired_q <= retired_q + CW'(1);
						end
						if (idx_s1 == SLOT_W'(SLOTS - 1)) begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_COMMIT: begin
					if (spawn_q) begin
						if (old_found_q) begin
							stolen_q[old_idx_q] <= 1'b1;
						end
						if (free_found_q) begin
							active_q[free_idx_q] <= 1'b1;
							stolen_q[free_idx_q] <= 1'b0;
							birth_ctr_q          <= birth_ctr_q + gva_pkg::BIRTH_W'(1);
						end
						counted_q <= counted_q + CW'(free_found_q) - CW'(old_found_q);
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						out_data_q <= result;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// non-stolen active count never exceeds the cap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		counted_q <= CW'(MAX_ACTIVE))
		else $error("active count above cap");

	// between items the count matches the slot flags
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(active_q & ~stolen_q) == int'(counted_q)))
		else $error("active count out of step with slot flags");

	// the granted slot was really free
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && spawn_q && free_found_q) |-> !active_q[free_idx_q])
		else $error("grant to a busy slot");

	// a steal never lands on the slot being granted
	a_steal_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && spawn_q && free_found_q && old_found_q)
		|-> (old_idx_q != free_idx_q))
		else $error("stolen slot equals granted slot");

endmodule

`default_nettype wire

@@ rtl/gva_slot_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gva_slot_ram #(
	parameter int DEPTH = gva_pkg::SLOTS_DEF,
	parameter int AW    = 5
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire gva_pkg::slot_entry_t  wr_data,
	input  wire logic [AW-1:0]         rd_addr,
	output gva_pkg::slot_entry_t       rd_data
);

	gva_pkg::slot_entry_t mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

@@ rtl/gva_slot_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared per-slot unit: tick aging/fading and birth compare for the oldest search.
module gva_slot_alu (
	input  wire gva_pkg::alu_req_t req,
	output gva_pkg::alu_rsp_t      rsp
);

	logic [gva_pkg::AGE_W-1:0]  age_n;
	logic [gva_pkg::FADE_W-1:0] fade_n;
	logic                       len_done;

	always_comb begin
		age_n    = req.entry.age + gva_pkg::AGE_W'(1);
		len_done = age_n >= req.entry.length;
		if (!req.stolen) begin
			fade_n = req.entry.fade;
		end else if (req.entry.fade > req.fade_step) begin
			fade_n = req.entry.fade - req.fade_step;
		end else begin
			fade_n = '0;
		end

		rsp.entry        = req.entry;
		rsp.entry.age    = age_n;
		rsp.entry.fade   = fade_n;
		rsp.done         = len_done || (req.stolen && (fade_n == '0));
		rsp.older        = req.entry.birth < req.best_birth;
	end

endmodule

`default_nettype wire
